[rtl/grc_pkg.sv]
// Shared constants, types and helper functions for the grid ray caster.
// Used by grc_div, grc_dpath, grc_ctrl and grid_raycast_column; no dependencies.
package grc_pkg;

    localparam int COORD_W       = 5;
    localparam int MAP_SIZE      = 2 ** COORD_W;
    localparam int ADDR_W        = 2 * COORD_W;
    localparam int MAP_DEPTH     = 2 ** ADDR_W;
    localparam int MP_W          = COORD_W + 2;
    localparam int STEP_LIMIT    = 2 * MAP_SIZE;
    localparam int CNT_W         = $clog2(STEP_LIMIT + 1);
    localparam int SCREEN_WIDTH  = 640;
    localparam int SCREEN_HEIGHT = 480;

    localparam int DIV_NUM_W = 40;
    localparam int DIV_DEN_W = 32;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

    localparam int CAM_W  = 19;
    localparam int RAY_W  = 22;
    localparam int PN_W   = 25;
    localparam int LH_W   = 27;

    // camera offset 2*column*65536/SCREEN_WIDTH = column*1024/5; divide by 5 with
    // ceil(2^22/5), exact for every dividend below 2^22
    localparam int CAM_RECIP = 838861;
    localparam int CAM_SHIFT = 22;

    localparam logic [31:0]     SAT32     = 32'hFFFF_FFFF;
    localparam logic [LH_W-1:0] HUGE_LH   = LH_W'(1) << 26;

    localparam logic [23:0] COLOR_RED    = 24'hFF0000;
    localparam logic [23:0] COLOR_GREEN  = 24'h00FF00;
    localparam logic [23:0] COLOR_BLUE   = 24'h0000FF;
    localparam logic [23:0] COLOR_WHITE  = 24'hFFFFFF;
    localparam logic [23:0] COLOR_YELLOW = 24'hFFFF00;

    typedef enum logic [2:0] {
        DIV_DX   = 3'd1,
        DIV_DY   = 3'd2,
        DIV_PERP = 3'd3,
        DIV_LH   = 3'd4
    } div_sel_t;

    typedef struct packed {
        logic     clr_en;
        logic     wr_cell;
        logic     load;
        logic     div_start;
        logic     div_take;
        div_sel_t div_sel;
        logic     ray_calc;
        logic     side_calc;
        logic     dda_step;
        logic     lh_huge;
        logic     out_load;
        logic     out_found;
    } cmd_t;

    typedef struct packed {
        logic clr_done;
        logic div_done;
        logic map_out;
        logic cell_hit;
        logic limit_hit;
        logic perp_zero;
        logic out_busy;
    } sts_t;

    function automatic logic [23:0] cell_color(input logic [7:0] v);
        logic [23:0] c;
        case (v)
            8'd1:    c = COLOR_RED;
            8'd2:    c = COLOR_GREEN;
            8'd3:    c = COLOR_BLUE;
            8'd4:    c = COLOR_WHITE;
            default: c = COLOR_YELLOW;
        endcase
        return c;
    endfunction

endpackage

[rtl/grc_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on grc_pkg for widths.
module grc_div (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [grc_pkg::DIV_NUM_W-1:0]   num,
    input  logic [grc_pkg::DIV_DEN_W-1:0]   den,
    output logic                            done,
    output logic [grc_pkg::DIV_NUM_W-1:0]   quot
);
    logic [grc_pkg::DIV_NUM_W-1:0] num_reg, num_next;
    logic [grc_pkg::DIV_DEN_W-1:0] den_reg;
    logic [grc_pkg::DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [grc_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                          busy_reg, done_reg;
    logic [grc_pkg::DIV_DEN_W:0]   trial;
    logic [grc_pkg::DIV_DEN_W+1:0] diff;
    logic                          ge;

    always_comb begin
        trial    = {rem_reg, num_reg[grc_pkg::DIV_NUM_W-1]};
        diff     = {1'b0, trial} - {2'b00, den_reg};
        ge       = ~diff[grc_pkg::DIV_DEN_W+1];
        rem_next = ge ? diff[grc_pkg::DIV_DEN_W-1:0] : trial[grc_pkg::DIV_DEN_W-1:0];
        num_next = {num_reg[grc_pkg::DIV_NUM_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= grc_pkg::DIV_CNT_W'(grc_pkg::DIV_NUM_W - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
        end else if (busy_reg) begin
            num_reg <= num_next;
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign quot = num_reg;
endmodule

[rtl/grc_dpath.sv]
// Datapath of the ray caster: map store, ray setup, DDA walk, slice math, result register.
// Depends on grc_pkg and grc_div.
module grc_dpath (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  grc_pkg::cmd_t           cmd,
    output grc_pkg::sts_t           sts,
    input  logic [9:0]              column,
    input  logic [4:0]              cell_x,
    input  logic [4:0]              cell_y,
    input  logic [7:0]              cell_value,
    input  logic [20:0]             pos_x,
    input  logic [20:0]             pos_y,
    input  logic signed [17:0]      dir_x,
    input  logic signed [17:0]      dir_y,
    input  logic signed [17:0]      plane_x,
    input  logic signed [17:0]      plane_y,
    input  logic                    m_tready,
    output logic                    m_tvalid,
    output logic [9:0]              out_column,
    output logic [9:0]              draw_start,
    output logic [9:0]              draw_end,
    output logic [23:0]             wall_color,
    output logic                    hit_side,
    output logic                    wall_found
);
    localparam int MW = grc_pkg::MP_W;
    localparam int RW = grc_pkg::RAY_W;

    logic [7:0]                   mem [grc_pkg::MAP_DEPTH];
    logic [7:0]                   rd_reg;
    logic [grc_pkg::ADDR_W:0]     clr_reg;

    logic [9:0]                   col_reg;
    logic [20:0]                  pos_x_reg, pos_y_reg;
    logic signed [17:0]           dir_x_reg, dir_y_reg, plane_x_reg, plane_y_reg;
    logic signed [grc_pkg::CAM_W-1:0] cam_reg;
    logic signed [RW-1:0]         ray_x_reg, ray_y_reg;
    logic [31:0]                  delta_x_reg, delta_y_reg, side_x_reg, side_y_reg;
    logic signed [MW-1:0]         mp_x_reg, mp_y_reg, mp_x_next, mp_y_next;
    logic [grc_pkg::CNT_W-1:0]    cnt_reg;
    logic                         axis_reg;
    logic [31:0]                  perp_reg;
    logic [grc_pkg::LH_W-1:0]     lh_reg;

    logic                         out_valid_reg;
    logic [9:0]                   o_col_reg, o_ds_reg, o_de_reg;
    logic [23:0]                  o_color_reg;
    logic                         o_side_reg, o_found_reg;

    logic [39:0]                  cam_prod;
    logic [17:0]                  cam_q;
    logic [RW-1:0]                mag_x, mag_y, mag_hit;
    logic signed [RW-1:0]         ray_hit;
    logic                         neg_hit;
    logic signed [MW-1:0]         mp_hit;
    logic [20:0]                  pos_hit;
    logic signed [grc_pkg::PN_W-1:0] pnum;
    logic [grc_pkg::PN_W-1:0]     pmag;
    logic [grc_pkg::DIV_NUM_W-1:0] div_num, quot;
    logic [grc_pkg::DIV_DEN_W-1:0] div_den;
    logic                         div_done;
    logic [31:0]                  quot_sat;
    logic signed [36:0]           prod_x, prod_y;
    logic [16:0]                  frac_x, frac_y;
    logic [48:0]                  sprod_x, sprod_y;
    logic                         step_axis;
    logic [32:0]                  sum_x, sum_y;
    logic [25:0]                  half;
    logic [26:0]                  de_sum;
    logic [9:0]                   ds_val, de_val;
    logic [23:0]                  color;
    logic                         we;
    logic [grc_pkg::ADDR_W-1:0]   waddr, raddr;
    logic [7:0]                   wdata;

    // camera offset: column*1024/5 by reciprocal multiplication
    always_comb begin
        cam_prod = 40'({column, 10'd0}) * 40'(grc_pkg::CAM_RECIP);
        cam_q    = cam_prod[grc_pkg::CAM_SHIFT+17:grc_pkg::CAM_SHIFT];
    end

    // ray magnitudes and hit-axis selection
    always_comb begin
        mag_x   = ray_x_reg[RW-1] ? RW'(-ray_x_reg) : RW'(ray_x_reg);
        mag_y   = ray_y_reg[RW-1] ? RW'(-ray_y_reg) : RW'(ray_y_reg);
        ray_hit = axis_reg ? ray_y_reg : ray_x_reg;
        mag_hit = axis_reg ? mag_y : mag_x;
        neg_hit = ray_hit[RW-1];
        mp_hit  = axis_reg ? mp_y_reg : mp_x_reg;
        pos_hit = axis_reg ? pos_y_reg : pos_x_reg;
        pnum    = (grc_pkg::PN_W'(mp_hit) <<< 16)
                - signed'({{(grc_pkg::PN_W-21){1'b0}}, pos_hit})
                + (neg_hit ? grc_pkg::PN_W'(65536) : grc_pkg::PN_W'(0));
        pmag    = pnum[grc_pkg::PN_W-1] ? grc_pkg::PN_W'(-pnum) : grc_pkg::PN_W'(pnum);
    end

    // divider operand select
    always_comb begin
        case (cmd.div_sel)
            grc_pkg::DIV_DX: begin
                div_num = 40'h01_0000_0000;
                div_den = 32'(mag_x);
            end
            grc_pkg::DIV_DY: begin
                div_num = 40'h01_0000_0000;
                div_den = 32'(mag_y);
            end
            grc_pkg::DIV_PERP: begin
                div_num = {pmag[23:0], 16'd0};
                div_den = 32'(mag_hit);
            end
            grc_pkg::DIV_LH: begin
                div_num = 40'(grc_pkg::SCREEN_HEIGHT * 65536);
                div_den = perp_reg;
            end
            default: begin
                div_num = '0;
                div_den = '0;
            end
        endcase
    end

    grc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quot    (quot)
    );

    assign quot_sat = (quot[39:32] != 8'd0) ? grc_pkg::SAT32 : quot[31:0];

    // ray setup products
    always_comb begin
        prod_x  = plane_x_reg * cam_reg;
        prod_y  = plane_y_reg * cam_reg;
        frac_x  = ray_x_reg[RW-1] ? {1'b0, pos_x_reg[15:0]} : 17'h10000 - {1'b0, pos_x_reg[15:0]};
        frac_y  = ray_y_reg[RW-1] ? {1'b0, pos_y_reg[15:0]} : 17'h10000 - {1'b0, pos_y_reg[15:0]};
        sprod_x = frac_x * delta_x_reg;
        sprod_y = frac_y * delta_y_reg;
    end

    // one DDA step
    always_comb begin
        step_axis = (side_x_reg < side_y_reg) ? 1'b0 : 1'b1;
        sum_x     = {1'b0, side_x_reg} + {1'b0, delta_x_reg};
        sum_y     = {1'b0, side_y_reg} + {1'b0, delta_y_reg};
        mp_x_next = mp_x_reg;
        mp_y_next = mp_y_reg;
        if (!step_axis) begin
            mp_x_next = ray_x_reg[RW-1] ? mp_x_reg - MW'(1) : mp_x_reg + MW'(1);
        end else begin
            mp_y_next = ray_y_reg[RW-1] ? mp_y_reg - MW'(1) : mp_y_reg + MW'(1);
        end
    end

    // map store: clear sweep and cell writes share the write port
    always_comb begin
        we    = cmd.clr_en | (cmd.wr_cell & (32'(cell_x) < grc_pkg::MAP_SIZE)
                                          & (32'(cell_y) < grc_pkg::MAP_SIZE));
        waddr = cmd.clr_en ? clr_reg[grc_pkg::ADDR_W-1:0]
                           : {cell_x[grc_pkg::COORD_W-1:0], cell_y[grc_pkg::COORD_W-1:0]};
        wdata = cmd.clr_en ? 8'd0 : cell_value;
        raddr = {mp_x_next[grc_pkg::COORD_W-1:0], mp_y_next[grc_pkg::COORD_W-1:0]};
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (cmd.dda_step) begin
            rd_reg <= mem[raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0;
        end else if (cmd.clr_en) begin
            clr_reg <= clr_reg + 1'b1;
        end
    end

    // cast registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            col_reg     <= column;
            pos_x_reg   <= pos_x;
            pos_y_reg   <= pos_y;
            dir_x_reg   <= dir_x;
            dir_y_reg   <= dir_y;
            plane_x_reg <= plane_x;
            plane_y_reg <= plane_y;
            cam_reg     <= signed'({1'b0, cam_q}) - grc_pkg::CAM_W'(65536);
            mp_x_reg    <= MW'(pos_x[20:16]);
            mp_y_reg    <= MW'(pos_y[20:16]);
            cnt_reg     <= '0;
            axis_reg    <= 1'b0;
        end
        if (cmd.div_take) begin
            case (cmd.div_sel)
                grc_pkg::DIV_DX:   delta_x_reg <= (mag_x == '0) ? grc_pkg::SAT32 : quot_sat;
                grc_pkg::DIV_DY:   delta_y_reg <= (mag_y == '0) ? grc_pkg::SAT32 : quot_sat;
                grc_pkg::DIV_PERP: perp_reg <= (mag_hit == '0) ? 32'd0 : quot_sat;
                grc_pkg::DIV_LH:   lh_reg <= quot[grc_pkg::LH_W-1:0];
                default: ;
            endcase
        end
        if (cmd.ray_calc) begin
            ray_x_reg <= RW'(dir_x_reg) + RW'(prod_x >>> 16);
            ray_y_reg <= RW'(dir_y_reg) + RW'(prod_y >>> 16);
        end
        if (cmd.side_calc) begin
            side_x_reg <= sprod_x[48] ? grc_pkg::SAT32 : sprod_x[47:16];
            side_y_reg <= sprod_y[48] ? grc_pkg::SAT32 : sprod_y[47:16];
        end
        if (cmd.dda_step) begin
            axis_reg <= step_axis;
            cnt_reg  <= cnt_reg + 1'b1;
            mp_x_reg <= mp_x_next;
            mp_y_reg <= mp_y_next;
            if (!step_axis) begin
                side_x_reg <= sum_x[32] ? grc_pkg::SAT32 : sum_x[31:0];
            end else begin
                side_y_reg <= sum_y[32] ? grc_pkg::SAT32 : sum_y[31:0];
            end
        end
        if (cmd.lh_huge) begin
            lh_reg <= grc_pkg::HUGE_LH;
        end
    end

    // slice rows and color
    always_comb begin
        half   = lh_reg[grc_pkg::LH_W-1:1];
        ds_val = (32'(half) >= grc_pkg::SCREEN_HEIGHT / 2) ? 10'd0
               : 10'(grc_pkg::SCREEN_HEIGHT / 2) - half[9:0];
        de_sum = 27'(half) + 27'(grc_pkg::SCREEN_HEIGHT / 2);
        de_val = (32'(de_sum) >= grc_pkg::SCREEN_HEIGHT - 1) ? 10'(grc_pkg::SCREEN_HEIGHT - 1)
               : de_sum[9:0];
        color  = grc_pkg::cell_color(rd_reg);
        if (axis_reg) begin
            color = (color >> 1) & 24'h7F7F7F;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            o_col_reg   <= col_reg;
            o_ds_reg    <= cmd.out_found ? ds_val : 10'd0;
            o_de_reg    <= cmd.out_found ? de_val : 10'd0;
            o_color_reg <= cmd.out_found ? color : 24'd0;
            o_side_reg  <= cmd.out_found & axis_reg;
            o_found_reg <= cmd.out_found;
        end
    end

    always_comb begin
        sts.clr_done  = (clr_reg == (grc_pkg::ADDR_W+1)'(grc_pkg::MAP_DEPTH - 1));
        sts.div_done  = div_done;
        sts.map_out   = mp_x_reg[MW-1] | mp_y_reg[MW-1]
                      | (32'(mp_x_reg) >= grc_pkg::MAP_SIZE)
                      | (32'(mp_y_reg) >= grc_pkg::MAP_SIZE);
        sts.cell_hit  = (rd_reg != 8'd0);
        sts.limit_hit = (32'(cnt_reg) == grc_pkg::STEP_LIMIT);
        sts.perp_zero = (perp_reg == 32'd0);
        sts.out_busy  = out_valid_reg & ~m_tready;
    end

    assign m_tvalid   = out_valid_reg;
    assign out_column = o_col_reg;
    assign draw_start = o_ds_reg;
    assign draw_end   = o_de_reg;
    assign wall_color = o_color_reg;
    assign hit_side   = o_side_reg;
    assign wall_found = o_found_reg;
endmodule

[rtl/grc_ctrl.sv]
// Sequencer of the ray caster: clear sweep, input handshake, divider jobs, DDA walk.
// Depends on grc_pkg; drives grc_dpath through cmd_t and reads sts_t.
module grc_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    input  logic          func,
    output logic          s_tready,
    input  grc_pkg::sts_t sts,
    output grc_pkg::cmd_t cmd
);
    typedef enum logic [9:0] {
        S_CLEAR    = 10'b00_0000_0001,
        S_IDLE     = 10'b00_0000_0010,
        S_DIV_GO   = 10'b00_0000_0100,
        S_DIV_WAIT = 10'b00_0000_1000,
        S_RAY      = 10'b00_0001_0000,
        S_SIDE     = 10'b00_0010_0000,
        S_STEP     = 10'b00_0100_0000,
        S_TEST     = 10'b00_1000_0000,
        S_PERP_CHK = 10'b01_0000_0000,
        S_FINISH   = 10'b10_0000_0000
    } state_t;

    state_t            state_reg, state_next;
    grc_pkg::div_sel_t sel_reg, sel_next;
    logic              found_reg, found_next;

    always_comb begin
        state_next = state_reg;
        sel_next   = sel_reg;
        found_next = found_reg;
        cmd        = '0;
        cmd.div_sel   = sel_reg;
        cmd.out_found = found_reg;
        s_tready   = 1'b0;
        case (state_reg)
            S_CLEAR: begin
                cmd.clr_en = 1'b1;
                if (sts.clr_done) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (func) begin
                        cmd.load   = 1'b1;
                        found_next = 1'b0;
                        state_next = S_RAY;
                    end else begin
                        cmd.wr_cell = 1'b1;
                    end
                end
            end
            S_DIV_GO: begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (sts.div_done) begin
                    cmd.div_take = 1'b1;
                    case (sel_reg)
                        grc_pkg::DIV_DX: begin
                            sel_next   = grc_pkg::DIV_DY;
                            state_next = S_DIV_GO;
                        end
                        grc_pkg::DIV_DY:   state_next = S_SIDE;
                        grc_pkg::DIV_PERP: state_next = S_PERP_CHK;
                        default:           state_next = S_FINISH;
                    endcase
                end
            end
            S_RAY: begin
                cmd.ray_calc = 1'b1;
                sel_next     = grc_pkg::DIV_DX;
                state_next   = S_DIV_GO;
            end
            S_SIDE: begin
                cmd.side_calc = 1'b1;
                state_next    = sts.map_out ? S_FINISH : S_STEP;
            end
            S_STEP: begin
                cmd.dda_step = 1'b1;
                state_next   = S_TEST;
            end
            S_TEST: begin
                if (sts.map_out) begin
                    state_next = S_FINISH;
                end else if (sts.cell_hit) begin
                    found_next = 1'b1;
                    sel_next   = grc_pkg::DIV_PERP;
                    state_next = S_DIV_GO;
                end else if (sts.limit_hit) begin
                    state_next = S_FINISH;
                end else begin
                    state_next = S_STEP;
                end
            end
            S_PERP_CHK: begin
                if (sts.perp_zero) begin
                    cmd.lh_huge = 1'b1;
                    state_next  = S_FINISH;
                end else begin
                    sel_next   = grc_pkg::DIV_LH;
                    state_next = S_DIV_GO;
                end
            end
            S_FINISH: begin
                if (!sts.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            sel_reg   <= grc_pkg::DIV_DX;
            found_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
            found_reg <= found_next;
        end
    end
endmodule

[rtl/grid_raycast_column.sv]
// Top level of the grid ray caster: stream ports, controller and datapath.
// Depends on grc_pkg, grc_ctrl, grc_dpath (and grc_div below it).
//
//  channel  | direction | tdata                         | tuser
//  ---------+-----------+-------------------------------+-----------------------
//  s_       | in        | cell write or cast parameters | func (0 write, 1 cast)
//  m_       | out       | one wall slice per cast       | none
//
// Sequence: a cell write is stored at its transfer. A cast forms its camera value at the
// transfer by a reciprocal multiplication, then runs up to four divisions
// (two reciprocals, perpendicular distance, line height) through one shared
// bit-serial divider, and walks the grid in DDA steps (step, map read) for at most
// 2*MAP_SIZE steps.
// Reset: the map store is swept to empty, one cell a cycle, over all MAP_DEPTH
// (1024) cells after reset; s_tready stays low meanwhile.
// Stalls: the result register holds a slice while m_tready is low; a new item
// is taken meanwhile and a cast waits at its end until the register frees.
module grid_raycast_column (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // column[9:0] cell_x[14:10] cell_y[19:15] cell_value[27:20] pos_x[48:28]
    // pos_y[69:49] dir_x[87:70] dir_y[105:88] plane_x[123:106] plane_y[141:124], zeros
    input  logic [143:0] s_tdata,
    // func[0]
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_column[9:0] draw_start[19:10] draw_end[29:20] wall_color[53:30]
    // hit_side[54] wall_found[55]
    output logic [55:0]  m_tdata
);
    grc_pkg::cmd_t cmd;
    grc_pkg::sts_t sts;

    logic [9:0]  out_column, draw_start, draw_end;
    logic [23:0] wall_color;
    logic        hit_side, wall_found;

    grc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .func     (s_tuser[0]),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    grc_dpath u_dpath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .column     (s_tdata[9:0]),
        .cell_x     (s_tdata[14:10]),
        .cell_y     (s_tdata[19:15]),
        .cell_value (s_tdata[27:20]),
        .pos_x      (s_tdata[48:28]),
        .pos_y      (s_tdata[69:49]),
        .dir_x      (signed'(s_tdata[87:70])),
        .dir_y      (signed'(s_tdata[105:88])),
        .plane_x    (signed'(s_tdata[123:106])),
        .plane_y    (signed'(s_tdata[141:124])),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .out_column (out_column),
        .draw_start (draw_start),
        .draw_end   (draw_end),
        .wall_color (wall_color),
        .hit_side   (hit_side),
        .wall_found (wall_found)
    );

    // pack the slice fields, lowest first
    assign m_tdata = {wall_found, hit_side, wall_color, draw_end, draw_start, out_column};

    // a miss carries nothing but its column
    a_miss_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !wall_found) |-> (draw_start == 10'd0 && draw_end == 10'd0
                                       && wall_color == 24'd0 && !hit_side))
        else $error("miss result carries slice data");

    // a slice never starts below its end
    a_slice_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && wall_found) |-> (draw_start <= draw_end))
        else $error("slice start below slice end");

    // halved colors have clear channel tops
    a_side_shade: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && hit_side) |-> (!wall_color[23] && !wall_color[15] && !wall_color[7]))
        else $error("y-side color not halved");

    // a new cast is only taken by the idle controller, never during the clear sweep
    a_no_take_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clr_en |-> !s_tready)
        else $error("input ready during map clear");
endmodule

[tb/testbench.sv]
// Stream-level check of grid_raycast_column: map writes and column casts with
// random idling on both channels. Depends on grc_pkg and the RTL top only.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [0:0] {
        FN_WRITE = 1'b0,
        FN_CAST  = 1'b1
    } fn_t;

    typedef struct packed {
        logic        wall_found;
        logic        hit_side;
        logic [23:0] wall_color;
        logic [9:0]  draw_end;
        logic [9:0]  draw_start;
        logic [9:0]  column;
    } slice_t;

    typedef struct {
        fn_t          fn;
        logic [143:0] payload;
    } item_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [143:0] s_tdata = '0;
    logic [0:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [55:0]  m_tdata;

    grid_raycast_column i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    item_t  pending_items[$];
    slice_t expected_slices[$];
    logic [7:0] grid_model[grc_pkg::MAP_SIZE][grc_pkg::MAP_SIZE];
    int     error_count = 0;
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Generous limit: ~450 items plus stall slack.
    initial begin
        #50ms;
        $display("CHECK FAILED");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic logic [31:0] sat_quotient(input logic [63:0] num,
                                                 input logic [63:0] den);
        logic [63:0] q;
        if (den == 0) return grc_pkg::SAT32;
        q = num / den;
        return (q > 64'hFFFF_FFFF) ? grc_pkg::SAT32 : q[31:0];
    endfunction

    function automatic longint floor16(input longint v);
        return v >>> 16;
    endfunction

    // Predict one cast: form the ray, walk the grid, size and color the slice.
    function automatic slice_t cast_slice(input logic [143:0] d);
        slice_t      s;
        longint      pos[2], dir[2], pln[2], ray[2], mpos[2], stp[2];
        longint      cam, num, mag_r, half, ds, de;
        logic [31:0] delta[2], side[2], perp;
        logic [63:0] frac, prod, lh, sum;
        int          axis;
        bit          found;
        logic [23:0] color;
        logic [7:0]  v;
        s = '0;
        axis = 0;
        found = 0;
        s.column = d[9:0];
        pos[0] = d[48:28];
        pos[1] = d[69:49];
        dir[0] = $signed(d[87:70]);
        dir[1] = $signed(d[105:88]);
        pln[0] = $signed(d[123:106]);
        pln[1] = $signed(d[141:124]);
        cam = (2 * longint'(d[9:0]) * 65536) / grc_pkg::SCREEN_WIDTH - 65536;
        for (int a = 0; a < 2; a++) begin
            frac = pos[a] & 16'hFFFF;
            ray[a] = dir[a] + floor16(pln[a] * cam);
            mpos[a] = pos[a] >>> 16;
            mag_r = ray[a] < 0 ? -ray[a] : ray[a];
            delta[a] = (ray[a] == 0) ? grc_pkg::SAT32 : sat_quotient(64'h1_0000_0000, mag_r);
            if (ray[a] < 0) stp[a] = -1;
            else begin
                stp[a] = 1;
                frac = 65536 - frac;
            end
            prod = (frac * delta[a]) >> 16;
            side[a] = prod > 64'hFFFF_FFFF ? grc_pkg::SAT32 : prod[31:0];
        end
        if (mpos[0] < grc_pkg::MAP_SIZE && mpos[1] < grc_pkg::MAP_SIZE) begin
            for (int n = 0; n < grc_pkg::STEP_LIMIT; n++) begin
                axis = (side[0] < side[1]) ? 0 : 1;
                sum = 64'(side[axis]) + delta[axis];
                side[axis] = sum > 64'hFFFF_FFFF ? grc_pkg::SAT32 : sum[31:0];
                mpos[axis] += stp[axis];
                if (mpos[axis] < 0 || mpos[axis] >= grc_pkg::MAP_SIZE) break;
                if (grid_model[mpos[0]][mpos[1]] != 0) begin
                    found = 1;
                    break;
                end
            end
        end
        if (!found) return s;
        num = mpos[axis] * 65536 - pos[axis] + (stp[axis] < 0 ? 65536 : 0);
        if (num < 0) num = -num;
        mag_r = ray[axis] < 0 ? -ray[axis] : ray[axis];
        perp = (ray[axis] == 0) ? 32'd0 : sat_quotient(64'(num) << 16, mag_r);
        lh = (perp == 0) ? 64'(grc_pkg::HUGE_LH)
                         : (64'(grc_pkg::SCREEN_HEIGHT) * 65536) / perp;
        half = lh / 2;
        ds = grc_pkg::SCREEN_HEIGHT / 2 - half;
        if (ds < 0) ds = 0;
        de = half + grc_pkg::SCREEN_HEIGHT / 2;
        if (de >= grc_pkg::SCREEN_HEIGHT) de = grc_pkg::SCREEN_HEIGHT - 1;
        v = grid_model[mpos[0]][mpos[1]];
        case (v)
            8'd1:    color = 24'hFF0000;
            8'd2:    color = 24'h00FF00;
            8'd3:    color = 24'h0000FF;
            8'd4:    color = 24'hFFFFFF;
            default: color = 24'hFFFF00;
        endcase
        if (axis == 1) color = (color >> 1) & 24'h7F7F7F;
        s.draw_start = ds[9:0];
        s.draw_end = de[9:0];
        s.wall_color = color;
        s.hit_side = axis[0];
        s.wall_found = 1'b1;
        return s;
    endfunction

    function automatic logic [143:0] pack_write(input int x, input int y, input int v);
        logic [143:0] d;
        d = 144'({$urandom, $urandom, $urandom, $urandom, $urandom});
        d[143:142] = 2'b00;
        d[14:10] = 5'(x);
        d[19:15] = 5'(y);
        d[27:20] = 8'(v);
        return d;
    endfunction

    function automatic logic [143:0] pack_cast(input int col, input int px, input int py,
                                               input int dx, input int dy,
                                               input int plx, input int ply);
        logic [143:0] d;
        d = '0;
        d[27:10] = 18'($urandom);
        d[9:0] = 10'(col);
        d[48:28] = 21'(px);
        d[69:49] = 21'(py);
        d[87:70] = 18'(dx);
        d[105:88] = 18'(dy);
        d[123:106] = 18'(plx);
        d[141:124] = 18'(ply);
        return d;
    endfunction

    task automatic queue_item(input fn_t fn, input logic [143:0] d);
        item_t it;
        it.fn = fn;
        it.payload = d;
        pending_items.push_back(it);
    endtask

    // A viewer in a cell interior, looking roughly along a random axis; one cast in twenty is fully random.
    function automatic logic [143:0] random_cast();
        int dx, dy, px, py;
        case ($urandom_range(0, 3))
            0: begin dx = 65536; dy = 0; end
            1: begin dx = -65536; dy = 0; end
            2: begin dx = 0; dy = 65536; end
            default: begin dx = 0; dy = -65536; end
        endcase
        dx += $urandom_range(0, 40000) - 20000;
        dy += $urandom_range(0, 40000) - 20000;
        px = ($urandom_range(1, 30) << 16) | $urandom_range(0, 65535);
        py = ($urandom_range(1, 30) << 16) | $urandom_range(0, 65535);
        if ($urandom_range(0, 19) == 0) begin
            px = $urandom;
            py = $urandom;
            dx = $urandom;
            dy = $urandom;
        end
        return pack_cast($urandom_range(0, 1023), px, py, dx,
                         dy, $urandom_range(0, 131071) - 65536,
                         $urandom_range(0, 131071) - 65536);
    endfunction

    // Driver: hold each transfer until accepted, idle at the phase's rate; stall m_tready likewise.
    always @(posedge aclk) begin
        item_t it;
        if (aresetn) begin
            if (!s_tvalid || s_tready) begin
                if (pending_items.size() != 0 &&
                    $urandom_range(0, 99) >= send_idle_pct) begin
                    it = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= it.payload;
                    s_tuser <= it.fn;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Predict at acceptance so casts see the map as of their own position; check slices in order.
    always @(posedge aclk) begin
        slice_t got, want;
        if (aresetn && s_tvalid && s_tready) begin
            if (s_tuser[0] == FN_WRITE) grid_model[s_tdata[14:10]][s_tdata[19:15]] = s_tdata[27:20];
            else expected_slices.push_back(cast_slice(s_tdata));
        end
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (expected_slices.size() == 0) begin
                report_mismatch("unexpected slice", got.column, 0);
            end else begin
                want = expected_slices.pop_front();
                if (got.column !== want.column)
                    report_mismatch("column", got.column, want.column);
                if (got.draw_start !== want.draw_start)
                    report_mismatch("draw_start", got.draw_start, want.draw_start);
                if (got.draw_end !== want.draw_end)
                    report_mismatch("draw_end", got.draw_end, want.draw_end);
                if (got.wall_color !== want.wall_color)
                    report_mismatch("wall_color", got.wall_color, want.wall_color);
                if (got.hit_side !== want.hit_side)
                    report_mismatch("hit_side", got.hit_side, want.hit_side);
                if (got.wall_found !== want.wall_found)
                    report_mismatch("wall_found", got.wall_found, want.wall_found);
            end
        end
    end

    task automatic drain();
        while (pending_items.size() != 0 || s_tvalid || expected_slices.size() != 0)
            @(posedge aclk);
    endtask

    initial begin
        int idle_set[4][2];
        idle_set = '{'{0, 0}, '{69, 0}, '{0, 69}, '{32, 32}};
        foreach (grid_model[x, y]) grid_model[x][y] = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty map, border walls, every palette entry, edge values.
        queue_item(FN_CAST, pack_cast(320, (5 << 16) | 32768, (5 << 16) | 32768,
                                      65536, 0, 0, 43690));
        for (int i = 0; i < grc_pkg::MAP_SIZE; i++) begin
            queue_item(FN_WRITE, pack_write(i, 0, 1 + (i % 6)));
        end
        queue_item(FN_WRITE, pack_write(0, 5, 2));
        queue_item(FN_WRITE, pack_write(31, 5, 255));
        queue_item(FN_WRITE, pack_write(5, 31, 3));
        queue_item(FN_WRITE, pack_write(10, 5, 4));
        queue_item(FN_CAST, pack_cast(0, (5 << 16) | 32768, (5 << 16) | 32768,
                                      -65536, 0, 0, 43690));
        queue_item(FN_CAST, pack_cast(1023, (5 << 16) | 32768, (5 << 16) | 32768,
                                      65536, 0, 0, 43690));
        queue_item(FN_CAST, pack_cast(320, (5 << 16) | 32768, (5 << 16) | 32768,
                                      0, -65536, -43690, 0));
        queue_item(FN_CAST, pack_cast(320, (5 << 16), (5 << 16), 0, 65536, 0, 0));
        queue_item(FN_CAST, pack_cast(320, (9 << 16) | 65535, (5 << 16), 65536, 0, 0, 0));
        queue_item(FN_CAST, pack_cast(640, 2097151, 2097151, 131071, -131072,
                                      -131072, 131071));
        queue_item(FN_CAST, pack_cast(320, (5 << 16) | 32768, (5 << 16) | 32768,
                                      0, 0, 0, 0));
        queue_item(FN_CAST, pack_cast(320, (5 << 16) | 32768, (20 << 16),
                                      -131072, 0, 131071, 131071));
        drain();

        // Random phases: scattered wall writes and clears mixed with casts into them.
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = idle_set[ph][0];
            recv_stall_pct = idle_set[ph][1];
            for (int k = 0; k < 100; k++) begin
                if ($urandom_range(0, 2) == 0)
                    queue_item(FN_WRITE, pack_write($urandom_range(0, 31),
                        $urandom_range(0, 31),
                        ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 255)));
                else
                    queue_item(FN_CAST, random_cast());
                // Hold the sender once until every slice is back.
                if (ph == 1 && k == 50) drain();
            end
            drain();
        end
        repeat (400) @(posedge aclk);
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
